[hw/rtl/jetp_pkg.sv]
// Shared types, constants and helper functions for the Julia escape-time pixel core.
package jetp_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int FRAC_BITS = 24;
  localparam int PIX_W     = 12;
  localparam int CNT_W     = 16;
  localparam int STEP_W    = 31;
  localparam int COLOR_W   = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // |z|^2 escape bound: 4 at 2*FRAC_BITS fraction bits
  localparam logic [63:0] ESC_BOUND = 64'd4 << (2 * FRAC_BITS);

  localparam logic signed [31:0] RST_C_REAL      = -32'sd23773689;
  localparam logic signed [31:0] RST_C_IMAG      = 32'sd0;
  localparam logic signed [31:0] RST_ORIGIN_REAL = -32'sd16777216;
  localparam logic [STEP_W-1:0]  RST_STEP_REAL   = 31'd27962;
  localparam logic signed [31:0] RST_ORIGIN_IMAG = -32'sd20132659;
  localparam logic [STEP_W-1:0]  RST_STEP_IMAG   = 31'd33554;
  localparam logic [CNT_W-1:0]   RST_ITER_LIMIT  = 16'd150;
  localparam logic [COLOR_W-1:0] RST_BASE_COLOR  = 24'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_C_REAL      = 3'd0,
    REG_C_IMAG      = 3'd1,
    REG_ORIGIN_REAL = 3'd2,
    REG_STEP_REAL   = 3'd3,
    REG_ORIGIN_IMAG = 3'd4,
    REG_STEP_IMAG   = 3'd5,
    REG_ITER_LIMIT  = 3'd6,
    REG_BASE_COLOR  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] c_real;
    logic signed [31:0] c_imag;
    logic signed [31:0] origin_real;
    logic [STEP_W-1:0]  step_real;
    logic signed [31:0] origin_imag;
    logic [STEP_W-1:0]  step_imag;
    logic [CNT_W-1:0]   iteration_limit;
    logic [COLOR_W-1:0] base_color;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP_MUL,
    ST_MAP_ADD,
    ST_MUL,
    ST_EVAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_in;    // capture the request
    logic map_mul;    // pixel * step products
    logic map_add;    // start point, clear count
    logic sq_mul;     // z products
    logic step;       // advance z and count
    logic load_out;   // fill result register
  } cmd_t;

  typedef struct packed {
    logic limit_zero;
    logic escaped;
    logic last_iter;
  } sts_t;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] clamp_pix(input logic [PIX_W-1:0] p);
    logic [PIX_W-1:0] r;
    if (32'(p) >= 32'(MAX_DIM)) begin
      r = PIX_W'(MAX_DIM - 1);
    end else begin
      r = p;
    end
    return r;
  endfunction

endpackage

[hw/rtl/jetp_cfg_regs.sv]
// Configuration register file for the Julia escape-time pixel core.
module jetp_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [jetp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [jetp_pkg::CFG_DATA_W-1:0]  cfg_data,
  output jetp_pkg::cfg_t                   cfg
);
  import jetp_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_C_REAL:      cfg_nxt.c_real          = cfg_data;
        REG_C_IMAG:      cfg_nxt.c_imag          = cfg_data;
        REG_ORIGIN_REAL: cfg_nxt.origin_real     = cfg_data;
        REG_STEP_REAL:   cfg_nxt.step_real       = cfg_data[STEP_W-1:0];
        REG_ORIGIN_IMAG: cfg_nxt.origin_imag     = cfg_data;
        REG_STEP_IMAG:   cfg_nxt.step_imag       = cfg_data[STEP_W-1:0];
        REG_ITER_LIMIT:  cfg_nxt.iteration_limit = cfg_data[CNT_W-1:0];
        REG_BASE_COLOR:  cfg_nxt.base_color      = cfg_data[COLOR_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.c_real          <= RST_C_REAL;
      cfg_r.c_imag          <= RST_C_IMAG;
      cfg_r.origin_real     <= RST_ORIGIN_REAL;
      cfg_r.step_real       <= RST_STEP_REAL;
      cfg_r.origin_imag     <= RST_ORIGIN_IMAG;
      cfg_r.step_imag       <= RST_STEP_IMAG;
      cfg_r.iteration_limit <= RST_ITER_LIMIT;
      cfg_r.base_color      <= RST_BASE_COLOR;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[hw/rtl/jetp_ctrl.sv]
// Sequencer for pixel mapping, iteration and result hand-off.
module jetp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  jetp_pkg::sts_t sts,
  output jetp_pkg::cmd_t cmd
);
  import jetp_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // result register can take a new value when empty or being drained
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_MAP_MUL;
      ST_MAP_MUL: state_nxt = ST_MAP_ADD;
      ST_MAP_ADD: state_nxt = sts.limit_zero ? ST_DONE : ST_MUL;
      ST_MUL:     state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (sts.escaped || sts.last_iter) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_DONE:    if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      ST_MAP_MUL: cmd.map_mul  = 1'b1;
      ST_MAP_ADD: cmd.map_add  = 1'b1;
      ST_MUL:     cmd.sq_mul   = 1'b1;
      ST_EVAL:    cmd.step     = !sts.escaped;
      ST_DONE:    cmd.load_out = out_free;
      default:    cmd = '0;
    endcase
  end

  assign out_valid_nxt = cmd.load_out ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[hw/rtl/jetp_datapath.sv]
// Fixed-point datapath: pixel mapping, z*z + c iteration and result register.
module jetp_datapath (
  input  logic                          clk,
  input  jetp_pkg::cfg_t                cfg,
  input  jetp_pkg::cmd_t                cmd,
  output jetp_pkg::sts_t                sts,
  input  logic [jetp_pkg::PIX_W-1:0]    in_column,
  input  logic [jetp_pkg::PIX_W-1:0]    in_row,
  output logic [jetp_pkg::PIX_W-1:0]    out_column,
  output logic [jetp_pkg::PIX_W-1:0]    out_row,
  output logic                          out_plotted,
  output logic [jetp_pkg::CNT_W-1:0]    out_count,
  output logic [31:0]                   out_color
);
  import jetp_pkg::*;

  localparam int PMUL_W = PIX_W + STEP_W;

  logic [PIX_W-1:0]   col_r, row_r;
  logic [PMUL_W-1:0]  pre_r, pim_r;
  logic signed [31:0] zr_r, zi_r;
  logic signed [63:0] rr_r, ii_r, ri_r;
  logic [CNT_W-1:0]   n_r;

  logic [63:0]        mag;
  logic signed [63:0] diff;
  logic [31:0]        zr_nxt, zi_nxt;
  logic [31:0]        zr0, zi0;

  assign zr0 = sat32(64'(cfg.origin_real) + $signed(64'(pre_r)));
  assign zi0 = sat32(64'(cfg.origin_imag) + $signed(64'(pim_r)));

  // both squares are non-negative, so the sum cannot wrap
  assign mag    = 64'(rr_r) + 64'(ii_r);
  assign diff   = rr_r - ii_r;
  assign zr_nxt = sat32((diff >>> FRAC_BITS) + 64'(cfg.c_real));
  assign zi_nxt = sat32((ri_r >>> (FRAC_BITS - 1)) + 64'(cfg.c_imag));

  assign sts.limit_zero = (cfg.iteration_limit == '0);
  assign sts.escaped    = (mag >= ESC_BOUND);
  assign sts.last_iter  = ((17'(n_r) + 17'd1) >= 17'(cfg.iteration_limit));

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      col_r <= in_column;
      row_r <= in_row;
    end
    if (cmd.map_mul) begin
      pre_r <= PMUL_W'(clamp_pix(col_r)) * PMUL_W'(cfg.step_real);
      pim_r <= PMUL_W'(clamp_pix(row_r)) * PMUL_W'(cfg.step_imag);
    end
    if (cmd.map_add) begin
      zr_r <= zr0;
      zi_r <= zi0;
      n_r  <= '0;
    end else if (cmd.step) begin
      zr_r <= zr_nxt;
      zi_r <= zi_nxt;
      n_r  <= n_r + CNT_W'(1);
    end
    if (cmd.sq_mul) begin
      rr_r <= 64'(zr_r) * 64'(zr_r);
      ii_r <= 64'(zi_r) * 64'(zi_r);
      ri_r <= 64'(zr_r) * 64'(zi_r);
    end
    if (cmd.load_out) begin
      out_column  <= col_r;
      out_row     <= row_r;
      out_plotted <= (n_r < cfg.iteration_limit);
      out_count   <= n_r;
      out_color   <= 32'(40'(cfg.base_color) * 40'(n_r));
    end
  end

endmodule

[hw/rtl/julia_escape_time_pixel_core.sv]
// Julia set escape-time pixel core: top level.
// Usage:
//   Present a pixel request (in_column, in_row) with in_valid; it is taken at a
//   clock edge where in_valid is high and in_stall is low. One result
//   (out_column, out_row, out_plotted, out_count, out_color) comes back per
//   request with out_valid and is taken when out_stall is low.
//   Write registers through cfg_wr_en/cfg_index/cfg_data only while idle.
// Sequence:
//   One request at a time. After acceptance a request goes through mapping
//   (the pixel * step products, then the start point), then, unless the limit
//   is zero, repeated escape tests (the three 32x32 products are registered,
//   then the test and the z update run on them), and ends with the result and
//   color product. The default iteration limit is 150.
//   The next request is taken in the cycle after the result moves to the output
//   register, even if the receiver has not taken it yet.
// Reset: rst_n (synchronous, active low) returns the sequencer to idle, drops
//   out_valid and loads the registers with their default view.
// Stall: a stalled result holds in the output register; the core finishes
//   the following request and then waits until the register frees up.
module julia_escape_time_pixel_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [jetp_pkg::PIX_W-1:0]      in_column,
  input  logic [jetp_pkg::PIX_W-1:0]      in_row,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [jetp_pkg::PIX_W-1:0]      out_column,
  output logic [jetp_pkg::PIX_W-1:0]      out_row,
  output logic                            out_plotted,
  output logic [jetp_pkg::CNT_W-1:0]      out_count,
  output logic [31:0]                     out_color,
  input  logic                            cfg_wr_en,
  input  logic [jetp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jetp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import jetp_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  jetp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  jetp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  jetp_datapath u_dp (
    .clk         (clk),
    .cfg         (cfg),
    .cmd         (cmd),
    .sts         (sts),
    .in_column   (in_column),
    .in_row      (in_row),
    .out_column  (out_column),
    .out_row     (out_row),
    .out_plotted (out_plotted),
    .out_count   (out_count),
    .out_color   (out_color)
  );

  // a taken request keeps the core busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("core accepted back-to-back requests");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count <= cfg.iteration_limit))
    else $error("result count beyond iteration limit");

  a_plotted_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_plotted == (out_count < cfg.iteration_limit)))
    else $error("plotted flag disagrees with count");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for julia_escape_time_pixel_core: random pixels, settings and stalls.
module tb_top;
  import jetp_pkg::*;

  localparam int PHASES         = 11;
  localparam int PHASE_ITEMS    = 100;
  localparam int HOLD_CYCLES    = 3000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 600000;

  typedef struct packed {
    logic [PIX_W-1:0] column;
    logic [PIX_W-1:0] row;
    logic             plotted;
    logic [CNT_W-1:0] count;
    logic [31:0]      color;
  } pixel_result_t;

  typedef logic [31:0] reg_words_t [8];

  class pixel_scoreboard;
    cfg_t          regs;
    pixel_result_t pending_pixels[$];
    int            mismatches;

    function new();
      regs.c_real          = RST_C_REAL;
      regs.c_imag          = RST_C_IMAG;
      regs.origin_real     = RST_ORIGIN_REAL;
      regs.step_real       = RST_STEP_REAL;
      regs.origin_imag     = RST_ORIGIN_IMAG;
      regs.step_imag       = RST_STEP_IMAG;
      regs.iteration_limit = RST_ITER_LIMIT;
      regs.base_color      = RST_BASE_COLOR;
      mismatches           = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [31:0] d);
      case (idx)
        REG_C_REAL:      regs.c_real = d;
        REG_C_IMAG:      regs.c_imag = d;
        REG_ORIGIN_REAL: regs.origin_real = d;
        REG_STEP_REAL:   regs.step_real = d[STEP_W-1:0];
        REG_ORIGIN_IMAG: regs.origin_imag = d;
        REG_STEP_IMAG:   regs.step_imag = d[STEP_W-1:0];
        REG_ITER_LIMIT:  regs.iteration_limit = d[CNT_W-1:0];
        REG_BASE_COLOR:  regs.base_color = d[COLOR_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp_q32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function int pixel_index(logic [PIX_W-1:0] p);
      return (int'(p) >= MAX_DIM) ? MAX_DIM - 1 : int'(p);
    endfunction

    function pixel_result_t escape_time(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row);
      pixel_result_t r;
      longint        zr, zi, rr, ii, ri;
      logic [63:0]   mag;
      logic [63:0]   bound;
      int unsigned   n;
      bound = 64'd4 << (2 * FRAC_BITS);
      zr = clamp_q32(longint'($signed(regs.origin_real)) +
                     longint'(pixel_index(col)) * longint'(regs.step_real));
      zi = clamp_q32(longint'($signed(regs.origin_imag)) +
                     longint'(pixel_index(row)) * longint'(regs.step_imag));
      n = 0;
      while (n < regs.iteration_limit) begin
        rr  = zr * zr;
        ii  = zi * zi;
        ri  = zr * zi;
        mag = 64'(rr) + 64'(ii);
        if (mag >= bound) break;
        zr = clamp_q32(((rr - ii) >>> FRAC_BITS) + longint'($signed(regs.c_real)));
        zi = clamp_q32((ri >>> (FRAC_BITS - 1)) + longint'($signed(regs.c_imag)));
        n++;
      end
      r.column  = col;
      r.row     = row;
      r.plotted = (n < regs.iteration_limit);
      r.count   = n[CNT_W-1:0];
      r.color   = {8'h00, regs.base_color} * n;
      return r;
    endfunction

    function void note_request(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row);
      pending_pixels.push_back(escape_time(col, row));
    endfunction

    function string describe(pixel_result_t r);
      return $sformatf("col %0d row %0d plotted %0d count %0d color %08h",
                       r.column, r.row, r.plotted, r.count, r.color);
    endfunction

    function void check_result(pixel_result_t got);
      pixel_result_t want;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", describe(got));
        return;
      end
      want = pending_pixels.pop_front();
      if (got.column !== want.column || got.row !== want.row ||
          got.plotted !== want.plotted || got.count !== want.count ||
          got.color !== want.color) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %s, got %s", describe(want), describe(got));
      end
    endfunction

    function int outstanding();
      return pending_pixels.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [PIX_W-1:0]      in_column;
  logic [PIX_W-1:0]      in_row;
  logic                  out_valid;
  logic                  out_stall;
  logic [PIX_W-1:0]      out_column;
  logic [PIX_W-1:0]      out_row;
  logic                  out_plotted;
  logic [CNT_W-1:0]      out_count;
  logic [31:0]           out_color;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pixel_scoreboard sb = new();
  bit              in_idle = 1'b1;
  bit              out_idle = 1'b1;
  bit              hold_pending = 1'b0;
  int unsigned     quiet_cycles = 0;

  julia_escape_time_pixel_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_column   (in_column),
    .in_row      (in_row),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_column  (out_column),
    .out_row     (out_row),
    .out_plotted (out_plotted),
    .out_count   (out_count),
    .out_color   (out_color),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  // End the run when neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: random stalls, one long hold on request.
  initial begin
    int            gap;
    pixel_result_t got;
    out_stall <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      gap = out_idle ? $urandom_range(0, 15) : 0;
      if (hold_pending) begin
        gap = HOLD_CYCLES;
        hold_pending = 1'b0;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      got.column  = out_column;
      got.row     = out_row;
      got.plotted = out_plotted;
      got.count   = out_count;
      got.color   = out_color;
      sb.check_result(got);
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
    int gap;
    gap = in_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_column <= col;
    in_row    <= row;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_request(col, row);
  endtask

  // Drop the request line and wait for every pending pixel to come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input reg_words_t w);
    for (int i = 0; i < 8; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data  <= w[i];
      sb.set_reg(cfg_reg_t'(i), w[i]);
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [31:0] signed_edge();
    case ($urandom_range(0, 3))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] step_edge();
    case ($urandom_range(0, 2))
      0:       return 32'h0;
      1:       return 32'h7fff_ffff;
      default: return $urandom() & 32'h7fff_ffff;
    endcase
  endfunction

  // Upper bits above each register's width carry noise; the core must drop them.
  task automatic pick_settings(input bit extreme, output reg_words_t w);
    logic [31:0] lim, base;
    if (extreme) begin
      w[REG_C_REAL]      = signed_edge();
      w[REG_C_IMAG]      = signed_edge();
      w[REG_ORIGIN_REAL] = signed_edge();
      w[REG_ORIGIN_IMAG] = signed_edge();
      w[REG_STEP_REAL]   = step_edge();
      w[REG_STEP_IMAG]   = step_edge();
      case ($urandom_range(0, 2))
        0:       lim = 0;
        1:       lim = 1;
        default: lim = $urandom_range(2, 64);
      endcase
      case ($urandom_range(0, 2))
        0:       base = 0;
        1:       base = 32'h00ff_ffff;
        default: base = $urandom() & 32'h00ff_ffff;
      endcase
    end else begin
      w[REG_C_REAL]      = int'($urandom_range(0, 1 << 26)) - (1 << 25);
      w[REG_C_IMAG]      = int'($urandom_range(0, 25165824 * 2)) - 25165824;
      w[REG_ORIGIN_REAL] = -int'($urandom_range(1 << 24, 1 << 25));
      w[REG_ORIGIN_IMAG] = -int'($urandom_range(1 << 24, 1 << 25));
      w[REG_STEP_REAL]   = $urandom_range(8000, 20000);
      w[REG_STEP_IMAG]   = $urandom_range(8000, 20000);
      lim                = $urandom_range(1, 200);
      base               = $urandom() & 32'h00ff_ffff;
    end
    w[REG_STEP_REAL]  = ($urandom() & 32'h8000_0000) | w[REG_STEP_REAL];
    w[REG_STEP_IMAG]  = ($urandom() & 32'h8000_0000) | w[REG_STEP_IMAG];
    w[REG_ITER_LIMIT] = ($urandom() & 32'hffff_0000) | lim;
    w[REG_BASE_COLOR] = ($urandom() & 32'hff00_0000) | base;
  endtask

  initial begin
    reg_words_t w;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_column <= '0;
    in_row    <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_C_REAL;
    cfg_data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default view: corners, a point near the origin and one off the real axis.
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd600, 12'd600);
    send_pixel(12'd1200, 12'd1200);
    wait_idle();

    // z and c at zero never escape: run the full 16-bit limit once.
    w[REG_C_REAL]      = 32'h0;
    w[REG_C_IMAG]      = 32'h0;
    w[REG_ORIGIN_REAL] = 32'h0;
    w[REG_STEP_REAL]   = 32'h0;
    w[REG_ORIGIN_IMAG] = 32'h0;
    w[REG_STEP_IMAG]   = 32'h0;
    w[REG_ITER_LIMIT]  = 32'h0000_ffff;
    w[REG_BASE_COLOR]  = 32'h00ff_ffff;
    program_regs(w);
    send_pixel(12'd123, 12'd456);
    wait_idle();

    w[REG_ITER_LIMIT] = 32'h0;
    w[REG_BASE_COLOR] = 32'h00ab_cdef;
    program_regs(w);
    send_pixel(12'd77, 12'd3000);
    wait_idle();

    // Start point at the edges of the signed range; the real part clamps at the top.
    w[REG_ORIGIN_REAL] = 32'h7fff_ffff;
    w[REG_ORIGIN_IMAG] = 32'h8000_0000;
    w[REG_STEP_REAL]   = 32'hffff_ffff;
    w[REG_STEP_IMAG]   = 32'hffff_ffff;
    w[REG_ITER_LIMIT]  = 32'h1;
    w[REG_BASE_COLOR]  = 32'h00ff_ffff;
    program_regs(w);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd1, 12'd0);
    send_pixel(12'd0, 12'd1);
    wait_idle();

    // Extreme constant pushes the first iterate out of range in both parts.
    w[REG_C_REAL]      = 32'h7fff_ffff;
    w[REG_C_IMAG]      = 32'h8000_0000;
    w[REG_ORIGIN_REAL] = 32'hffe0_0000;
    w[REG_ORIGIN_IMAG] = 32'h0010_0000;
    w[REG_STEP_REAL]   = 32'h0;
    w[REG_STEP_IMAG]   = 32'h0;
    w[REG_ITER_LIMIT]  = 32'h5;
    program_regs(w);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd7, 12'd9);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      pick_settings(p % 3 == 2, w);
      program_regs(w);
      in_idle  = (p != 1) && ($urandom_range(0, 3) != 0);
      out_idle = (p != 1) && ($urandom_range(0, 3) != 0);
      if (p == 0) hold_pending = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 3 && i == PHASE_ITEMS / 2) wait_idle();
        send_pixel(PIX_W'($urandom_range(0, 4095)), PIX_W'($urandom_range(0, 4095)));
      end
      wait_idle();
    end

    repeat (50) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
